// ----- rtl/ffha_pkg.sv -----
package ffha_pkg;

  localparam int unsigned MARK_W  = 8;
  localparam int unsigned REQ_W   = 16;
  localparam int unsigned OFF_W   = 15;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned NUM_W   = 13;
  localparam int unsigned BYTES_W = 15;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_STATUS = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_NOT_START = 2'd1,
    ERR_NOT_ALLOC = 2'd2
  } err_e;

  typedef enum logic {
    CFG_HEAP_LEN  = 1'b0,
    CFG_HEAP_MARK = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [REQ_W-1:0]  req_bytes;
    logic [MARK_W-1:0] block_mark;
    logic [OFF_W-1:0]  block_offset;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic [OFF_W-1:0]   mem_offset;
    logic [MARK_W-1:0]  mark_out;
    logic [1:0]         error_code;
    logic [NUM_W-1:0]   num_blocks;
    logic [NUM_W-1:0]   num_free_blocks;
    logic [BYTES_W-1:0] free_bytes;
    logic [BYTES_W-1:0] max_free_bytes;
    logic [CNT_W-1:0]   total_alloc_requests;
    logic [CNT_W-1:0]   alloc_successes;
    logic [CNT_W-1:0]   free_requests;
  } out_t;

endpackage

// ----- rtl/ffha_hdr_mem.sv -----
module ffha_hdr_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned WW    = 25
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [WW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [WW-1:0] rdata_o
);

  logic [WW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/first_fit_heap_allocator.sv -----
// Channel   Signals                          Handshake
// --------  -------------------------------  -------------------------------------
// command   start, busy, req_i               beat taken when start && !busy
// result    done_o, res_o                    one-cycle strobe, no back-pressure
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i  written on any edge with cfg_we_i high
//
// One command at a time. An allocate or status walk reads the block headers in turn,
// absorbs each free block that follows a free one by merging, takes a fit step for
// every free run met (plus a probe of the next header unless the run reaches the
// fence) and an extra split step; a free reads the one header it names and, if it is
// allocated, rewrites it. The single header memory gives one read and one write per cycle.
// Reset and every heap_len write start a clearing sweep over all HEAP_GRANULES
// headers of the header memory; busy stays high meanwhile.
// The receiver cannot stall: a result beat is on res_o only while done_o is high.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_GRANULES = 4096,
  parameter int unsigned GRANULE_BYTES = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  ffha_pkg::in_t                req_i,
  output logic                         done_o,
  output ffha_pkg::out_t               res_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [ffha_pkg::CFG_W-1:0]   cfg_wdata_i
);

  localparam int unsigned AW = $clog2(HEAP_GRANULES);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned SW = $clog2(GRANULE_BYTES);
  localparam int unsigned MW = PW + 5;
  localparam int unsigned NW = ffha_pkg::REQ_W + 1;
  localparam int unsigned HL_RESET = (HEAP_GRANULES < 4096) ? HEAP_GRANULES : 4096;
  localparam longint unsigned RECIP =
    ((64'd1 << 32) + 64'(GRANULE_BYTES) - 64'd1) / 64'(GRANULE_BYTES);

  typedef struct packed {
    logic              start;
    logic              alloc;
    logic [7:0]        tag;
    logic [SW-1:0]     spare;
    logic [AW-1:0]     len;
  } hdr_t;

  localparam int unsigned WW = $bits(hdr_t);

  typedef enum logic [9:0] {
    ST_CLEAR = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_PREP  = 10'b0000000100,
    ST_WALK  = 10'b0000001000,
    ST_MERGE = 10'b0000010000,
    ST_FIT   = 10'b0000100000,
    ST_SPLIT = 10'b0001000000,
    ST_FCHK  = 10'b0010000000,
    ST_FREE  = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [PW-1:0] heap_len_q, heap_len_d;
  logic [7:0]    heap_mark_q, heap_mark_d;
  logic [7:0]    reform_mark_q, reform_mark_d;
  logic [AW-1:0] clr_q, clr_d;

  // command and walk state
  ffha_pkg::in_t cmd_q, cmd_d;
  logic [NW-1:0] n_q, n_d;
  logic [NW-1:0] reqp_q, reqp_d;
  logic [ffha_pkg::OFF_W-1:0] q_q, q_d;
  logic [AW-1:0] g_q, g_d;
  logic [PW-1:0] nx_q, nx_d;
  logic [PW-1:0] run_q, run_d;
  logic [SW-1:0] spare_q, spare_d;
  logic [AW-1:0] rem_q, rem_d;
  logic [AW-1:0] remlen_q, remlen_d;
  logic          fvalid_q, fvalid_d;

  // result and counters
  logic                          ok_q, ok_d;
  logic [ffha_pkg::OFF_W-1:0]    memo_q, memo_d;
  logic [7:0]                    marko_q, marko_d;
  logic [1:0]                    err_q, err_d;
  logic [ffha_pkg::NUM_W-1:0]    nb_q, nb_d, nfb_q, nfb_d;
  logic [ffha_pkg::BYTES_W-1:0]  fb_q, fb_d;
  logic [MW-1:0]                 mfb_q, mfb_d;
  logic [ffha_pkg::CNT_W-1:0]    req_cnt_q, req_cnt_d;
  logic [ffha_pkg::CNT_W-1:0]    succ_cnt_q, succ_cnt_d;
  logic [ffha_pkg::CNT_W-1:0]    rel_cnt_q, rel_cnt_d;

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  hdr_t          wr_hdr, rd_hdr;
  logic [WW-1:0] mem_rdata;

  logic [PW-1:0] used, blk, nxt, fit_len, fit_mem;
  logic [MW-1:0] fit_bytes;
  logic [31:0]   cfg_v;
  logic [PW-1:0] hl_clamped;

  ffha_hdr_mem #(
    .DEPTH (HEAP_GRANULES),
    .AW    (AW),
    .WW    (WW)
  ) u_hdr_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wr_hdr),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_hdr = hdr_t'(mem_rdata);
  assign used   = heap_len_q - PW'(1);
  // a zero length counts as one granule
  assign blk    = (rd_hdr.len == '0) ? PW'(1) : PW'(rd_hdr.len);

  // merged run, clamped to the end of the walked area
  assign fit_len   = ((PW'(g_q) + run_q) > used) ? (used - PW'(g_q)) : run_q;
  assign fit_mem   = fit_len - PW'(1);
  assign fit_bytes = MW'(fit_mem) * MW'(GRANULE_BYTES);

  assign cfg_v      = 32'(cfg_wdata_i);
  assign hl_clamped = (cfg_v < 32'd2) ? PW'(2) :
                      (cfg_v > 32'(HEAP_GRANULES)) ? PW'(HEAP_GRANULES) : PW'(cfg_v);

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

  always_comb begin
    res_o                      = '0;
    res_o.ok                   = ok_q;
    res_o.mem_offset           = memo_q;
    res_o.mark_out             = marko_q;
    res_o.error_code           = err_q;
    res_o.num_blocks           = nb_q;
    res_o.num_free_blocks      = nfb_q;
    res_o.free_bytes           = fb_q;
    res_o.max_free_bytes       = ffha_pkg::BYTES_W'(mfb_q);
    res_o.total_alloc_requests = req_cnt_q;
    res_o.alloc_successes      = succ_cnt_q;
    res_o.free_requests        = rel_cnt_q;
  end

  always_comb begin
    state_d       = state_q;
    heap_len_d    = heap_len_q;
    heap_mark_d   = heap_mark_q;
    reform_mark_d = reform_mark_q;
    clr_d         = clr_q;
    cmd_d         = cmd_q;
    n_d           = n_q;
    reqp_d        = reqp_q;
    q_d           = q_q;
    g_d           = g_q;
    nx_d          = nx_q;
    run_d         = run_q;
    spare_d       = spare_q;
    rem_d         = rem_q;
    remlen_d      = remlen_q;
    fvalid_d      = fvalid_q;
    ok_d          = ok_q;
    memo_d        = memo_q;
    marko_d       = marko_q;
    err_d         = err_q;
    nb_d          = nb_q;
    nfb_d         = nfb_q;
    fb_d          = fb_q;
    mfb_d         = mfb_q;
    req_cnt_d     = req_cnt_q;
    succ_cnt_d    = succ_cnt_q;
    rel_cnt_d     = rel_cnt_q;
    mem_we        = 1'b0;
    mem_waddr     = g_q;
    mem_raddr     = g_q;
    wr_hdr        = '0;
    nxt           = '0;

    case (state_q)
      ST_CLEAR: begin
        // sweep down, the last write forms the single free block at granule 0
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == '0) begin
          wr_hdr.start = 1'b1;
          wr_hdr.tag   = reform_mark_q;
          wr_hdr.len   = AW'(heap_len_q - PW'(1));
          state_d      = ST_IDLE;
        end else begin
          clr_d = clr_q - AW'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          cmd_d  = req_i;
          ok_d   = 1'b0;
          memo_d = '0;
          marko_d = '0;
          err_d  = ffha_pkg::ERR_NONE;
          nb_d   = '0;
          nfb_d  = '0;
          fb_d   = '0;
          mfb_d  = '0;
          reqp_d = (req_i.req_bytes == '0) ? NW'(1) : NW'(req_i.req_bytes);
          if (req_i.mode == ffha_pkg::MODE_ALLOC) begin
            req_cnt_d = req_cnt_q + 1'b1;
          end
          state_d = ST_PREP;
        end
      end

      ST_PREP: begin
        // divide by the granule size through a reciprocal multiply
        n_d = NW'(((64'(reqp_q) + 64'(GRANULE_BYTES - 1)) * RECIP) >> 32);
        q_d = ffha_pkg::OFF_W'((64'(cmd_q.block_offset) * RECIP) >> 32);
        g_d = '0;
        case (cmd_q.mode)
          ffha_pkg::MODE_ALLOC,
          ffha_pkg::MODE_STATUS: begin
            mem_raddr = '0;
            state_d   = ST_WALK;
          end
          ffha_pkg::MODE_FREE: begin
            state_d = ST_FCHK;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end

      ST_FCHK: begin
        g_d       = AW'(q_q - 1'b1);
        mem_raddr = AW'(q_q - 1'b1);
        fvalid_d  = (q_q != '0) &&
                    (32'(q_q) * GRANULE_BYTES == 32'(cmd_q.block_offset)) &&
                    (32'(q_q) - 32'd1 < 32'(used));
        state_d   = ST_FREE;
      end

      ST_FREE: begin
        if (fvalid_q && rd_hdr.start) begin
          if (rd_hdr.alloc) begin
            mem_we       = 1'b1;
            wr_hdr.start = 1'b1;
            wr_hdr.tag   = heap_mark_q;
            wr_hdr.len   = rd_hdr.len;
            marko_d      = rd_hdr.tag;
            ok_d         = 1'b1;
            rel_cnt_d    = rel_cnt_q + 1'b1;
          end else begin
            err_d = ffha_pkg::ERR_NOT_ALLOC;
          end
        end else begin
          err_d = ffha_pkg::ERR_NOT_START;
        end
        state_d = ST_DONE;
      end

      ST_WALK: begin
        if (cmd_q.mode == ffha_pkg::MODE_STATUS) begin
          nb_d = nb_q + 1'b1;
        end
        nxt = PW'(g_q) + blk;
        if (rd_hdr.alloc) begin
          // skip an allocated block
          if (nxt < used) begin
            g_d       = AW'(nxt);
            mem_raddr = AW'(nxt);
          end else begin
            ok_d    = (cmd_q.mode == ffha_pkg::MODE_STATUS);
            state_d = ST_DONE;
          end
        end else begin
          spare_d = rd_hdr.spare;
          run_d   = blk;
          if (nxt < used) begin
            nx_d      = nxt;
            mem_raddr = AW'(nxt);
            state_d   = ST_MERGE;
          end else begin
            state_d = ST_FIT;
          end
        end
      end

      ST_MERGE: begin
        if (rd_hdr.start && !rd_hdr.alloc) begin
          // absorb the next free block, drop its start
          mem_we       = 1'b1;
          mem_waddr    = AW'(nx_q);
          wr_hdr       = rd_hdr;
          wr_hdr.start = 1'b0;
          run_d        = run_q + blk;
          nxt          = nx_q + blk;
          if (nxt < used) begin
            nx_d      = nxt;
            mem_raddr = AW'(nxt);
          end else begin
            state_d = ST_FIT;
          end
        end else begin
          state_d = ST_FIT;
        end
      end

      ST_FIT: begin
        mem_we       = 1'b1;
        wr_hdr.start = 1'b1;
        wr_hdr.tag   = heap_mark_q;
        wr_hdr.spare = spare_q;
        wr_hdr.len   = AW'(fit_len);
        nxt          = PW'(g_q) + fit_len;
        if (cmd_q.mode == ffha_pkg::MODE_ALLOC &&
            32'(n_q) <= 32'(fit_mem)) begin
          wr_hdr.alloc = 1'b1;
          wr_hdr.tag   = cmd_q.block_mark;
          wr_hdr.spare = SW'(32'(n_q) * GRANULE_BYTES - 32'(reqp_q));
          succ_cnt_d   = succ_cnt_q + 1'b1;
          ok_d         = 1'b1;
          memo_d       = ffha_pkg::OFF_W'((32'(g_q) + 32'd1) * GRANULE_BYTES);
          if (32'(n_q) < 32'(fit_mem)) begin
            // split off the tail as a free block
            wr_hdr.len = AW'(n_q + 1'b1);
            rem_d      = AW'(32'(g_q) + 32'(n_q) + 32'd1);
            remlen_d   = AW'(32'(fit_mem) - 32'(n_q));
            state_d    = ST_SPLIT;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          if (cmd_q.mode == ffha_pkg::MODE_STATUS) begin
            nfb_d = nfb_q + 1'b1;
            fb_d  = fb_q + ffha_pkg::BYTES_W'(fit_bytes);
            if (fit_bytes > mfb_q) begin
              mfb_d = fit_bytes;
            end
          end
          if (nxt < used) begin
            g_d       = AW'(nxt);
            mem_raddr = AW'(nxt);
            state_d   = ST_WALK;
          end else begin
            ok_d    = (cmd_q.mode == ffha_pkg::MODE_STATUS);
            state_d = ST_DONE;
          end
        end
      end

      ST_SPLIT: begin
        mem_we       = 1'b1;
        mem_waddr    = rem_q;
        wr_hdr.start = 1'b1;
        wr_hdr.tag   = heap_mark_q;
        wr_hdr.len   = remlen_q;
        state_d      = ST_DONE;
      end

      ST_DONE: begin
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // register writes; a heap_len write restarts the sweep
    if (cfg_we_i) begin
      if (cfg_idx_i == ffha_pkg::CFG_HEAP_LEN) begin
        heap_len_d    = hl_clamped;
        reform_mark_d = heap_mark_q;
        clr_d         = AW'(HEAP_GRANULES - 1);
        state_d       = ST_CLEAR;
      end else begin
        heap_mark_d = cfg_wdata_i[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      heap_len_q    <= PW'(HL_RESET);
      heap_mark_q   <= '0;
      reform_mark_q <= '0;
      clr_q         <= AW'(HEAP_GRANULES - 1);
      req_cnt_q     <= '0;
      succ_cnt_q    <= '0;
      rel_cnt_q     <= '0;
    end else begin
      state_q       <= state_d;
      heap_len_q    <= heap_len_d;
      heap_mark_q   <= heap_mark_d;
      reform_mark_q <= reform_mark_d;
      clr_q         <= clr_d;
      req_cnt_q     <= req_cnt_d;
      succ_cnt_q    <= succ_cnt_d;
      rel_cnt_q     <= rel_cnt_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    n_q      <= n_d;
    reqp_q   <= reqp_d;
    q_q      <= q_d;
    g_q      <= g_d;
    nx_q     <= nx_d;
    run_q    <= run_d;
    spare_q  <= spare_d;
    rem_q    <= rem_d;
    remlen_q <= remlen_d;
    fvalid_q <= fvalid_d;
    ok_q     <= ok_d;
    memo_q   <= memo_d;
    marko_q  <= marko_d;
    err_q    <= err_d;
    nb_q     <= nb_d;
    nfb_q    <= nfb_d;
    fb_q     <= fb_d;
    mfb_q    <= mfb_d;
  end

endmodule
